@@ hw/rtl/sphere_magnet_field_defines.svh @@
// Assertion macros for the sphere field block.
// Included by the checker; depends on nothing else.
`ifndef SPHERE_MAGNET_FIELD_DEFINES_SVH
`define SPHERE_MAGNET_FIELD_DEFINES_SVH

// Implication, checked only while out of reset.
`define SMF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sphere field check failed");

// Next-cycle implication, checked through reset as well.
`define SMF_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sphere field check failed");

`endif

@@ hw/rtl/smf_pkg.sv @@
// Shared constants for the sphere field pipeline.
// No dependencies; used by the top level, the divider and the checker.
package smf_pkg;

    localparam int COORD_W    = 32;
    localparam int QUAT_W     = 16;
    localparam int QUAT_FRAC  = QUAT_W - 2;
    localparam int MAT_W      = QUAT_W + 4;
    localparam int UNIT_FRAC  = 28;
    localparam int RATIO_FRAC = 30;
    localparam int SQ_STEPS   = COORD_W;
    localparam int DIV_STEPS  = COORD_W - 1;
    localparam int DIV_NUM_W  = (COORD_W - 1) + RATIO_FRAC;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4 * QUAT_W;
    localparam int SMF_LAT    = 15 + SQ_STEPS + DIV_STEPS;

    // Exact x/3 for x < 2^34: (x * DIV3_MUL) >> DIV3_SH
    localparam logic [33:0] DIV3_MUL = 34'h2_AAAA_AAAB;
    localparam int          DIV3_SH  = 35;
    localparam logic signed [63:0] VEC_LIMIT = (64'sd1 <<< 33) - 64'sd1;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POL_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POL_Y  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POL_Z  = 3'd7;

    localparam logic [CFG_DATA_W-1:0] QUAT_RST   = 64'h4000_0000_0000_0000;
    localparam logic [COORD_W-2:0]    RADIUS_RST = 31'd1677722;
    localparam logic [COORD_W-1:0]    POLZ_RST   = 32'h0100_0000;

endpackage

@@ hw/rtl/smf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on smf_pkg; o_quo is the quotient register of the last stage.
module smf_div (
    input  logic                           i_clk,
    input  logic [smf_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [smf_pkg::COORD_W-1:0]    i_den,
    output logic [smf_pkg::DIV_STEPS-1:0]  o_quo
);
    import smf_pkg::*;

    logic [COORD_W-1:0]   r_rem [1:DIV_STEPS-1];
    logic [COORD_W-1:0]   r_den [1:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_num [1:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_quo [1:DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [COORD_W-1:0]   c_rem;
        logic [COORD_W-1:0]   c_den;
        logic [DIV_STEPS-1:0] c_num;
        logic [DIV_STEPS-1:0] c_quo;
        logic [COORD_W:0]     n_t;
        logic [COORD_W:0]     n_d;
        logic                 n_ge;

        if (j == 0) begin : g_first
            // quotient fits DIV_STEPS bits, so the top part is below the divisor
            assign c_rem = COORD_W'(i_num[DIV_NUM_W-1:DIV_STEPS]);
            assign c_den = i_den;
            assign c_num = i_num[DIV_STEPS-1:0];
            assign c_quo = '0;
        end else begin : g_next
            assign c_rem = r_rem[j];
            assign c_den = r_den[j];
            assign c_num = r_num[j];
            assign c_quo = r_quo[j];
        end

        always_comb begin
            n_t  = {c_rem, c_num[DIV_STEPS-1-j]};
            n_ge = (n_t >= {1'b0, c_den});
            n_d  = n_t - {1'b0, c_den};
        end

        always_ff @(posedge i_clk) begin
            r_quo[j+1] <= {c_quo[DIV_STEPS-2:0], n_ge};
        end

        if (j < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j+1] <= n_ge ? n_d[COORD_W-1:0] : n_t[COORD_W-1:0];
                r_den[j+1] <= c_den;
                r_num[j+1] <= c_num;
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS];

endmodule

@@ hw/rtl/sphere_magnet_field.sv @@
// Magnetic field of a uniformly polarised sphere, one observation point per request.
// Depends on smf_pkg and smf_div.
//
// Usage
//  - Request channel: a point (i_obs_x/y/z, Q8.24) is taken at a rising edge with
//    start high and busy low. busy is low once r_run is set after reset, so a
//    new point may be offered every cycle.
//  - Result channel: o_valid is high for exactly one cycle with o_field_x/y/z
//    (world frame, Q8.24, saturated) and o_inside_sphere. The receiver cannot
//    stall, so no back-pressure exists and nothing is held.
//  - Results pass through the 32-stage square root and the 31-stage dividers for
//    R/r and the unit vector; throughput is one point per cycle.
//  - Configuration: i_cfg_we with i_cfg_idx/i_cfg_data writes one register per
//    cycle. Only write while no request is in flight. After a write the quaternion
//    lands in r_quat, and the rotation matrix r_mat is rebuilt from it.
//  - Reset (synchronous, active low): registers return to their defaults
//    (centre 0, identity orientation, radius ~0.1, polarisation +z 1.0), every
//    in-flight request is dropped and busy is high until r_run is set after reset.
module sphere_magnet_field (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [smf_pkg::COORD_W-1:0]    i_obs_x,
    input  logic signed [smf_pkg::COORD_W-1:0]    i_obs_y,
    input  logic signed [smf_pkg::COORD_W-1:0]    i_obs_z,
    input  logic                                  i_cfg_we,
    input  logic [smf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [smf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                  o_valid,
    output logic signed [smf_pkg::COORD_W-1:0]    o_field_x,
    output logic signed [smf_pkg::COORD_W-1:0]    o_field_y,
    output logic signed [smf_pkg::COORD_W-1:0]    o_field_z,
    output logic                                  o_inside_sphere
);
    import smf_pkg::*;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // signed shift right, rounding toward zero
    function automatic logic signed [63:0] f_trunc(input logic signed [63:0] x,
                                                   input int unsigned n);
        logic signed [63:0] bias;
        bias = (x < 0) ? ((64'sd1 <<< n) - 64'sd1) : 64'sd0;
        return (x + bias) >>> n;
    endfunction

    function automatic logic signed [COORD_W-1:0] f_sat(input logic signed [63:0] x);
        logic signed [COORD_W-1:0] res;
        if (x > SAT_HI) begin
            res = SAT_HI[COORD_W-1:0];
        end else if (x < SAT_LO) begin
            res = SAT_LO[COORD_W-1:0];
        end else begin
            res = x[COORD_W-1:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- config
    logic signed [COORD_W-1:0] r_pos [3];
    logic signed [COORD_W-1:0] r_pol [3];
    logic [CFG_DATA_W-1:0]     r_quat;
    logic [COORD_W-2:0]        r_rad;
    logic                      r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
            r_pol[0] <= '0;
            r_pol[1] <= '0;
            r_pol[2] <= POLZ_RST;
            r_quat   <= QUAT_RST;
            r_rad    <= RADIUS_RST;
            r_run    <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POS_X:  r_pos[0] <= i_cfg_data[COORD_W-1:0];
                    CFG_POS_Y:  r_pos[1] <= i_cfg_data[COORD_W-1:0];
                    CFG_POS_Z:  r_pos[2] <= i_cfg_data[COORD_W-1:0];
                    CFG_QUAT:   r_quat   <= i_cfg_data;
                    CFG_RADIUS: r_rad    <= i_cfg_data[COORD_W-2:0];
                    CFG_POL_X:  r_pol[0] <= i_cfg_data[COORD_W-1:0];
                    CFG_POL_Y:  r_pol[1] <= i_cfg_data[COORD_W-1:0];
                    CFG_POL_Z:  r_pol[2] <= i_cfg_data[COORD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy = !r_run;

    // Rotation matrix of q, entries truncated to Q.14. Rebuilt every cycle.
    logic signed [QUAT_W-1:0]   q_w, q_x, q_y, q_z;
    logic signed [2*QUAT_W-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
    logic signed [2*QUAT_W+2:0] n_raw [3][3];
    logic signed [MAT_W-1:0]    r_mat [3][3];
    logic [2*COORD_W-3:0]       r_rr;

    assign q_w = r_quat[4*QUAT_W-1:3*QUAT_W];
    assign q_x = r_quat[3*QUAT_W-1:2*QUAT_W];
    assign q_y = r_quat[2*QUAT_W-1:QUAT_W];
    assign q_z = r_quat[QUAT_W-1:0];

    always_comb begin
        p_ww = q_w * q_w;
        p_xx = q_x * q_x;
        p_yy = q_y * q_y;
        p_zz = q_z * q_z;
        p_xy = q_x * q_y;
        p_xz = q_x * q_z;
        p_yz = q_y * q_z;
        p_wx = q_w * q_x;
        p_wy = q_w * q_y;
        p_wz = q_w * q_z;
        n_raw[0][0] = (2*QUAT_W+3)'(p_ww) + (2*QUAT_W+3)'(p_xx)
                    - (2*QUAT_W+3)'(p_yy) - (2*QUAT_W+3)'(p_zz);
        n_raw[1][1] = (2*QUAT_W+3)'(p_ww) - (2*QUAT_W+3)'(p_xx)
                    + (2*QUAT_W+3)'(p_yy) - (2*QUAT_W+3)'(p_zz);
        n_raw[2][2] = (2*QUAT_W+3)'(p_ww) - (2*QUAT_W+3)'(p_xx)
                    - (2*QUAT_W+3)'(p_yy) + (2*QUAT_W+3)'(p_zz);
        n_raw[0][1] = ((2*QUAT_W+3)'(p_xy) - (2*QUAT_W+3)'(p_wz)) <<< 1;
        n_raw[0][2] = ((2*QUAT_W+3)'(p_xz) + (2*QUAT_W+3)'(p_wy)) <<< 1;
        n_raw[1][0] = ((2*QUAT_W+3)'(p_xy) + (2*QUAT_W+3)'(p_wz)) <<< 1;
        n_raw[1][2] = ((2*QUAT_W+3)'(p_yz) - (2*QUAT_W+3)'(p_wx)) <<< 1;
        n_raw[2][0] = ((2*QUAT_W+3)'(p_xz) - (2*QUAT_W+3)'(p_wy)) <<< 1;
        n_raw[2][1] = ((2*QUAT_W+3)'(p_yz) + (2*QUAT_W+3)'(p_wx)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_mat[i][j] <= MAT_W'(f_trunc(64'(n_raw[i][j]), QUAT_FRAC));
            end
        end
        r_rr <= r_rad * r_rad;
    end

    // ------------------------------------------------------ front stages A-E
    logic signed [COORD_W-1:0] obs [3];
    assign obs[0] = i_obs_x;
    assign obs[1] = i_obs_y;
    assign obs[2] = i_obs_z;

    logic                              r_a_v, r_b_v, r_c_v, r_d_v;
    logic signed [COORD_W:0]           r_a_d  [3];
    logic signed [COORD_W+MAT_W:0]     r_b_pr [3][3];
    logic signed [COORD_W-1:0]         r_c_p  [3];
    logic [COORD_W-1:0]                r_d_a  [3];
    logic [2*COORD_W-1:0]              r_d_sq [3];
    logic [2:0]                        r_d_neg;

    // magnitude of each body-frame coordinate
    logic [COORD_W-1:0]                n_c_a  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_a[i] = r_c_p[i][COORD_W-1] ? (~r_c_p[i] + 1'b1) : r_c_p[i];
        end
    end

    // square-root pipeline, entry 0 is stage E
    logic                   r_sq_v   [0:SQ_STEPS];
    logic                   r_sq_in  [0:SQ_STEPS];
    logic [2:0]             r_sq_neg [0:SQ_STEPS];
    logic [COORD_W-1:0]     r_sq_a   [0:SQ_STEPS][3];
    logic [2*COORD_W-1:0]   r_sq_s   [0:SQ_STEPS-1];
    logic [COORD_W:0]       r_sq_rem [0:SQ_STEPS-1];
    logic [COORD_W-1:0]     r_sq_root[0:SQ_STEPS];

    logic [2*COORD_W-1:0]   n_s;
    assign n_s = r_d_sq[0] + r_d_sq[1] + r_d_sq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
            r_c_v     <= 1'b0;
            r_d_v     <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else begin
            r_a_v     <= start && !busy;
            r_b_v     <= r_a_v;
            r_c_v     <= r_b_v;
            r_d_v     <= r_c_v;
            r_sq_v[0] <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_d[i] <= (COORD_W+1)'(obs[i]) - (COORD_W+1)'(r_pos[i]);
            // inverse rotation: transposed matrix
            for (int j = 0; j < 3; j++) begin
                r_b_pr[i][j] <= r_mat[j][i] * r_a_d[j];
            end
            r_c_p[i] <= f_sat(f_trunc(64'(r_b_pr[i][0]) + 64'(r_b_pr[i][1])
                                      + 64'(r_b_pr[i][2]), QUAT_FRAC));
            r_d_neg[i] <= r_c_p[i][COORD_W-1];
            r_d_a[i]   <= n_c_a[i];
            r_d_sq[i]  <= n_c_a[i] * n_c_a[i];
            r_sq_a[0][i] <= r_d_a[i];
        end
        r_sq_neg[0]  <= r_d_neg;
        r_sq_in[0]   <= (n_s <= (2*COORD_W)'(r_rr));
        r_sq_s[0]    <= n_s;
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    // Integer square root, two radicand bits per stage
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        logic [COORD_W+2:0] n_t;
        logic [COORD_W+2:0] n_trial;
        logic               n_ge;

        always_comb begin
            n_t     = {r_sq_rem[g], r_sq_s[g][2*COORD_W-1-2*g -: 2]};
            n_trial = (COORD_W+3)'({r_sq_root[g], 2'b01});
            n_ge    = (n_t >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[g+1] <= 1'b0;
            end else begin
                r_sq_v[g+1] <= r_sq_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_root[g+1] <= {r_sq_root[g][COORD_W-2:0], n_ge};
            r_sq_in[g+1]   <= r_sq_in[g];
            r_sq_neg[g+1]  <= r_sq_neg[g];
            r_sq_a[g+1]    <= r_sq_a[g];
        end

        if (g < SQ_STEPS - 1) begin : g_carry
            logic [COORD_W+2:0] n_d;
            assign n_d = n_t - n_trial;
            always_ff @(posedge i_clk) begin
                r_sq_s[g+1]   <= r_sq_s[g];
                r_sq_rem[g+1] <= n_ge ? n_d[COORD_W:0] : n_t[COORD_W:0];
            end
        end
    end

    // ------------------------------------------------ dividers: R/r and p/r
    logic [DIV_STEPS-1:0] w_k;
    logic [DIV_STEPS-1:0] w_uq [3];

    smf_div u_div_k (
        .i_clk (i_clk),
        .i_num ({r_rad, RATIO_FRAC'(0)}),
        .i_den (r_sq_root[SQ_STEPS]),
        .o_quo (w_k)
    );

    for (genvar i = 0; i < 3; i++) begin : g_udiv
        smf_div u_div_u (
            .i_clk (i_clk),
            .i_num (DIV_NUM_W'({r_sq_a[SQ_STEPS][i], UNIT_FRAC'(0)})),
            .i_den (r_sq_root[SQ_STEPS]),
            .o_quo (w_uq[i])
        );
    end

    logic       r_dv_v   [1:DIV_STEPS];
    logic       r_dv_in  [1:DIV_STEPS];
    logic [2:0] r_dv_neg [1:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[1] <= 1'b0;
        end else begin
            r_dv_v[1] <= r_sq_v[SQ_STEPS];
        end
        r_dv_in[1]  <= r_sq_in[SQ_STEPS];
        r_dv_neg[1] <= r_sq_neg[SQ_STEPS];
    end

    for (genvar k = 1; k < DIV_STEPS; k++) begin : g_dvdly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_dv_in[k+1]  <= r_dv_in[k];
            r_dv_neg[k+1] <= r_dv_neg[k];
        end
    end

    // --------------------------------------------------- back stages F-O
    logic                        r_f_v, r_g_v, r_h_v, r_i_v, r_j_v, r_k_v, r_l_v;
    logic                        r_m_v, r_n_v, r_o_v;
    logic                        r_f_in, r_g_in, r_h_in, r_i_in, r_j_in, r_k_in, r_l_in;
    logic                        r_m_in, r_n_in, r_o_in;
    logic [DIV_STEPS-1:0]        r_f_k, r_g_k;
    logic signed [UNIT_FRAC+1:0] r_f_u [3];
    logic signed [UNIT_FRAC+1:0] r_g_u [3];
    logic signed [UNIT_FRAC+1:0] r_h_u [3];
    logic [2*DIV_STEPS-1:0]      r_g_kk;
    logic signed [63:0]          r_g_um [3];
    logic [2*DIV_STEPS-1:0]      r_h_k3p;
    logic signed [34:0]          r_h_dot;
    logic [DIV_STEPS-1:0]        r_i_k3, r_j_k3;
    logic signed [63:0]          r_i_tp [3];
    logic signed [34:0]          r_j_vec [3];
    logic signed [65:0]          r_k_vk [3];
    logic [67:0]                 r_l_qd [3];
    logic [2:0]                  r_l_neg;
    logic [67:0]                 r_l_bq [3];
    logic [2:0]                  r_l_bneg;
    logic signed [COORD_W-1:0]   r_m_b  [3];
    logic signed [COORD_W+MAT_W-1:0] r_n_pr [3][3];
    logic signed [COORD_W-1:0]   r_o_f  [3];

    logic signed [63:0] n_dot;
    logic signed [63:0] n_t   [3];
    logic signed [63:0] n_v   [3];
    logic [65:0]        n_vmag[3];
    logic signed [COORD_W:0] n_m2 [3];
    logic [COORD_W:0]   n_m2mag [3];
    logic signed [63:0] n_bo  [3];
    logic signed [63:0] n_bi  [3];

    always_comb begin
        n_dot = f_trunc(r_g_um[0] + r_g_um[1] + r_g_um[2], UNIT_FRAC);
        for (int i = 0; i < 3; i++) begin
            n_t[i] = f_trunc(r_i_tp[i], UNIT_FRAC);
            n_v[i] = 64'sd3 * n_t[i] - 64'(r_pol[i]);
            if (n_v[i] > VEC_LIMIT) begin
                n_v[i] = VEC_LIMIT;
            end else if (n_v[i] < -VEC_LIMIT) begin
                n_v[i] = -VEC_LIMIT;
            end
            n_vmag[i]  = r_k_vk[i][65] ? (~r_k_vk[i] + 1'b1) : r_k_vk[i];
            n_m2[i]    = {r_pol[i], 1'b0};
            n_m2mag[i] = n_m2[i][COORD_W] ? (~n_m2[i] + 1'b1) : n_m2[i];
            n_bo[i] = r_l_neg[i] ? -$signed(64'(r_l_qd[i][67:DIV3_SH]))
                                 :  $signed(64'(r_l_qd[i][67:DIV3_SH]));
            n_bi[i] = r_l_bneg[i] ? -$signed(64'(r_l_bq[i][67:DIV3_SH]))
                                  :  $signed(64'(r_l_bq[i][67:DIV3_SH]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
            r_l_v <= 1'b0;
            r_m_v <= 1'b0;
            r_n_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_f_v <= r_dv_v[DIV_STEPS];
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
            r_k_v <= r_j_v;
            r_l_v <= r_k_v;
            r_m_v <= r_l_v;
            r_n_v <= r_m_v;
            r_o_v <= r_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        // F: signed unit vector, Q.28
        r_f_k  <= w_k;
        r_f_in <= r_dv_in[DIV_STEPS];
        for (int i = 0; i < 3; i++) begin
            r_f_u[i] <= r_dv_neg[DIV_STEPS][i] ? -$signed(w_uq[i][UNIT_FRAC+1:0])
                                               :  $signed(w_uq[i][UNIT_FRAC+1:0]);
        end
        // G: (R/r)^2 and u.M terms
        r_g_kk <= r_f_k * r_f_k;
        r_g_k  <= r_f_k;
        r_g_in <= r_f_in;
        for (int i = 0; i < 3; i++) begin
            r_g_um[i] <= r_f_u[i] * r_pol[i];
            r_g_u[i]  <= r_f_u[i];
        end
        // H: (R/r)^3 product, dot
        r_h_k3p <= r_g_kk[2*DIV_STEPS-2:RATIO_FRAC] * r_g_k;
        r_h_dot <= n_dot[34:0];
        r_h_u   <= r_g_u;
        r_h_in  <= r_g_in;
        // I: (u.M) u
        r_i_k3 <= r_h_k3p[2*DIV_STEPS-2:RATIO_FRAC];
        r_i_in <= r_h_in;
        for (int i = 0; i < 3; i++) begin
            r_i_tp[i] <= r_h_dot * r_h_u[i];
        end
        // J: 3(u.M)u - M, clamped
        r_j_k3 <= r_i_k3;
        r_j_in <= r_i_in;
        for (int i = 0; i < 3; i++) begin
            r_j_vec[i] <= n_v[i][34:0];
        end
        // K: scale by (R/r)^3
        r_k_in <= r_j_in;
        for (int i = 0; i < 3; i++) begin
            r_k_vk[i] <= r_j_vec[i] * $signed({1'b0, r_j_k3});
        end
        // L: divide by 3 << 30 through the reciprocal; inside value 2M/3 alongside
        r_l_in <= r_k_in;
        for (int i = 0; i < 3; i++) begin
            r_l_neg[i]  <= r_k_vk[i][65];
            r_l_qd[i]   <= n_vmag[i][63:RATIO_FRAC] * DIV3_MUL;
            r_l_bneg[i] <= n_m2[i][COORD_W];
            r_l_bq[i]   <= n_m2mag[i] * DIV3_MUL;
        end
        // M: body-frame field
        r_m_in <= r_l_in;
        for (int i = 0; i < 3; i++) begin
            r_m_b[i] <= r_l_in ? f_sat(n_bi[i]) : f_sat(n_bo[i]);
        end
        // N, O: rotate back to the world frame
        r_n_in <= r_m_in;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_n_pr[i][j] <= r_mat[i][j] * r_m_b[j];
            end
        end
        r_o_in <= r_n_in;
        for (int i = 0; i < 3; i++) begin
            r_o_f[i] <= f_sat(f_trunc(64'(r_n_pr[i][0]) + 64'(r_n_pr[i][1])
                                      + 64'(r_n_pr[i][2]), QUAT_FRAC));
        end
    end

    assign o_valid         = r_o_v;
    assign o_inside_sphere = r_o_in;
    assign o_field_x       = r_o_f[0];
    assign o_field_y       = r_o_f[1];
    assign o_field_z       = r_o_f[2];

endmodule

@@ hw/rtl/smf_checker.sv @@
// Port-level checks for sphere_magnet_field, attached by bind.
// Depends on smf_pkg and sphere_magnet_field_defines.svh.
`include "sphere_magnet_field_defines.svh"

module smf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    import smf_pkg::*;

    // every result traces back to a request exactly one latency earlier
    `SMF_ASSERT_IMP(a_lat, i_clk, i_rst_n, o_valid, $past(start && !busy, SMF_LAT))
    // reset drops everything in flight and holds off requests
    `SMF_ASSERT_NXT(a_rst_busy, i_clk, !i_rst_n, busy)
    `SMF_ASSERT_NXT(a_rst_out, i_clk, !i_rst_n, !o_valid)

endmodule

bind sphere_magnet_field smf_checker u_smf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
